>>> src/hpp_pkg.sv
`default_nettype none

package hpp_pkg;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_LOAD = 11'b000_0000_0010,
    ST_RED  = 11'b000_0000_0100,
    ST_HMUL = 11'b000_0000_1000,
    ST_HDIV = 11'b000_0001_0000,
    ST_PMUL = 11'b000_0010_0000,
    ST_GROW = 11'b000_0100_0000,
    ST_STEP = 11'b000_1000_0000,
    ST_MDIV = 11'b001_0000_0000,
    ST_OPT  = 11'b010_0000_0000,
    ST_EMIT = 11'b100_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    REG_STRIKE   = 2'd0,
    REG_DISCOUNT = 2'd1,
    REG_ASSETS   = 2'd2,
    REG_STEPS    = 2'd3
  } cfg_reg_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_INCR = 1'b1;

  localparam logic [32:0] LN2_Q28   = 33'd186065280;
  localparam logic [33:0] LN2_X12   = 34'd2232783360;
  localparam logic [29:0] ONE_Q28   = 30'd268435456;
  localparam logic [3:0]  EXP_TERMS = 4'd10;

  // Reciprocals ceil(2^33 / m), exact for dividends below 2^29.
  function automatic logic [31:0] horner_recip(input logic [3:0] m);
    logic [31:0] r;
    case (m)
      4'd3:    r = 32'd2863311531;
      4'd4:    r = 32'd2147483648;
      4'd5:    r = 32'd1717986919;
      4'd6:    r = 32'd1431655766;
      4'd7:    r = 32'd1227133514;
      4'd8:    r = 32'd1073741824;
      4'd9:    r = 32'd954437177;
      4'd10:   r = 32'd858993460;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/hpp_ram.sv
`default_nettype none

module hpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/himalaya_path_payoff_core.sv
`default_nettype none

// Path payoff of a Himalaya basket option. A spot load is written directly, or via a
// load state when it overwrites a spot whose path-start copy has not yet been taken. An
// increment for an asset still in the basket runs the transfer, a five-step range
// reduction, a ten-term Horner exp with a multiply and a divide state per term, then
// the price multiply, the write-back into the working-price memory and the step update.
// An increment for a removed asset goes straight to the step update. The last increment
// of a path adds the bit-serial mean divider and the discount multiply, and waits while
// an earlier result is still held at the output. Spots and working prices sit in two
// simple dual-port memories with registered reads, read when an input is taken.
module himalaya_path_payoff_core #(
  parameter int MAX_ASSETS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [2:0]  in_asset_slot,
  input  wire logic signed [31:0] in_sample_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_option_value,
  output logic [31:0]      out_mean_of_best,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
  localparam int NW = $clog2(MAX_ASSETS + 1);

  hpp_pkg::state_t state_r, state_nxt;

  logic [31:0]           strike_r;
  logic [16:0]           disc_r;
  logic [3:0]            assets_r;
  logic [15:0]           steps_r;

  logic [AW-1:0]         asset_pos_r;
  logic [15:0]           step_pos_r;
  logic [MAX_ASSETS-1:0] mask_r;
  logic [MAX_ASSETS-1:0] fresh_r;
  logic [31:0]           best_r;
  logic [AW-1:0]         best_slot_r;
  logic [39:0]           sum_r;
  logic                  out_valid_r;

  logic [31:0]           sample_r;
  logic [AW-1:0]         slot_r;
  logic [32:0]           u_r;
  logic [4:0]            kq_r;
  logic [2:0]            jcnt_r;
  logic [3:0]            m_r;
  logic [29:0]           e_r;
  logic [57:0]           p_r;
  logic [61:0]           prod_r;
  logic [39:0]           dq_r;
  logic [NW-1:0]         rem_r;
  logic [NW-1:0]         d_r;
  logic [5:0]            dcnt_r;
  logic [48:0]           opt_prod_r;
  logic [31:0]           out_opt_r;
  logic [31:0]           out_mean_r;

  logic [NW-1:0]         n_act;
  logic [15:0]           steps_eff;
  logic [MAX_ASSETS-1:0] act_bits;
  logic                  pos_active;
  logic                  last_asset;
  logic                  last_step;
  logic                  path_open;
  logic                  in_xfer;
  logic [AW-1:0]         slot_addr;
  logic                  slot_ok;
  logic                  preserve;
  logic                  direct_load;
  logic [31:0]           spot_rdata;
  logic [31:0]           work_rdata;
  logic [31:0]           price_cur;
  logic [33:0]           u_init;
  logic [32:0]           red_sub;
  logic                  red_ge;
  logic [28:0]           h_t;
  logic [60:0]           h_mq;
  logic [28:0]           h_q;
  logic [29:0]           e_next;
  logic [5:0]            grow_sh;
  logic [61:0]           grow_shifted;
  logic [31:0]           grow_val;
  logic [39:0]           sum_add;
  logic                  do_remove;
  logic [NW-1:0]         div_sel;
  logic [NW:0]           rem_sh;
  logic                  div_ge;
  logic [NW:0]           rem_new;
  logic [31:0]           mean_sat;
  logic [31:0]           opt_val;
  logic                  can_emit;

  logic                  spot_we;
  logic [AW-1:0]         spot_waddr;
  logic [31:0]           spot_wdata;
  logic [AW-1:0]         spot_raddr;
  logic                  work_we;
  logic [AW-1:0]         work_waddr;
  logic [31:0]           work_wdata;
  logic                  work_re;

  always_comb begin
    if (assets_r == 4'd0) begin
      n_act = NW'(1);
    end else if (int'(assets_r) > MAX_ASSETS) begin
      n_act = NW'(MAX_ASSETS);
    end else begin
      n_act = NW'(assets_r);
    end
    for (int b = 0; b < MAX_ASSETS; b++) begin
      act_bits[b] = (b < int'(n_act));
    end
  end

  assign steps_eff  = (steps_r == 16'd0) ? 16'd1 : steps_r;
  assign pos_active = (int'(asset_pos_r) < int'(n_act)) && mask_r[asset_pos_r];
  assign last_asset = !((int'(asset_pos_r) + 1) < int'(n_act));
  assign last_step  = !(({1'b0, step_pos_r} + 17'd1) < {1'b0, steps_eff});
  assign path_open  = (asset_pos_r != '0) || (step_pos_r != 16'd0);

  assign in_stall   = (state_r != hpp_pkg::ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign slot_addr  = AW'(in_asset_slot);
  assign slot_ok    = int'(in_asset_slot) < MAX_ASSETS;
  assign preserve   = slot_ok && path_open && fresh_r[slot_addr];
  assign direct_load = in_xfer && (in_command == hpp_pkg::CMD_LOAD) && slot_ok && !preserve;

  assign price_cur  = fresh_r[asset_pos_r] ? spot_rdata : work_rdata;

  assign u_init     = 34'(in_sample_value) + hpp_pkg::LN2_X12;
  assign red_sub    = hpp_pkg::LN2_Q28 << jcnt_r;
  assign red_ge     = (u_r >= red_sub);

  assign h_t        = p_r[56:28];
  assign h_mq       = {32'd0, h_t} * {29'd0, hpp_pkg::horner_recip(m_r)};
  always_comb begin
    if (m_r == 4'd1) begin
      h_q = h_t;
    end else if (m_r == 4'd2) begin
      h_q = {1'b0, h_t[28:1]};
    end else begin
      h_q = {1'b0, h_mq[60:33]};
    end
  end
  assign e_next     = hpp_pkg::ONE_Q28 + 30'(h_q);

  assign grow_sh      = 6'd40 - {1'b0, kq_r};
  assign grow_shifted = prod_r >> grow_sh;
  assign grow_val     = (|grow_shifted[61:32]) ? 32'hFFFF_FFFF : grow_shifted[31:0];

  assign sum_add    = sum_r + 40'(best_r);
  assign do_remove  = |(mask_r & act_bits);
  assign div_sel    = (steps_eff < 16'(n_act)) ? NW'(steps_eff) : n_act;

  assign rem_sh     = {rem_r, dq_r[39]};
  assign div_ge     = (rem_sh >= {1'b0, d_r});
  assign rem_new    = div_ge ? (rem_sh - {1'b0, d_r}) : rem_sh;

  assign mean_sat   = (|dq_r[39:32]) ? 32'hFFFF_FFFF : dq_r[31:0];
  assign opt_val    = opt_prod_r[48] ? 32'hFFFF_FFFF : opt_prod_r[47:16];
  assign can_emit   = !out_valid_r || !out_stall;

  assign spot_we    = direct_load || (state_r == hpp_pkg::ST_LOAD);
  assign spot_waddr = (state_r == hpp_pkg::ST_LOAD) ? slot_r : slot_addr;
  assign spot_wdata = (state_r == hpp_pkg::ST_LOAD) ? sample_r : in_sample_value;
  assign spot_raddr = (in_command == hpp_pkg::CMD_INCR) ? asset_pos_r : slot_addr;
  assign work_we    = (state_r == hpp_pkg::ST_LOAD) || (state_r == hpp_pkg::ST_GROW);
  assign work_waddr = (state_r == hpp_pkg::ST_LOAD) ? slot_r : asset_pos_r;
  assign work_wdata = (state_r == hpp_pkg::ST_LOAD) ? spot_rdata : grow_val;
  assign work_re    = in_xfer && (in_command == hpp_pkg::CMD_INCR);

  hpp_ram #(.WIDTH(32), .DEPTH(MAX_ASSETS)) u_spot_ram (
    .clk   (clk),
    .we    (spot_we),
    .waddr (spot_waddr),
    .wdata (spot_wdata),
    .re    (in_xfer),
    .raddr (spot_raddr),
    .rdata (spot_rdata)
  );

  hpp_ram #(.WIDTH(32), .DEPTH(MAX_ASSETS)) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (work_waddr),
    .wdata (work_wdata),
    .re    (work_re),
    .raddr (asset_pos_r),
    .rdata (work_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hpp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_command == hpp_pkg::CMD_LOAD) begin
            state_nxt = preserve ? hpp_pkg::ST_LOAD : hpp_pkg::ST_IDLE;
          end else begin
            state_nxt = pos_active ? hpp_pkg::ST_RED : hpp_pkg::ST_STEP;
          end
        end
      end
      hpp_pkg::ST_LOAD: state_nxt = hpp_pkg::ST_IDLE;
      hpp_pkg::ST_RED: begin
        if (jcnt_r == 3'd0) begin
          state_nxt = hpp_pkg::ST_HMUL;
        end
      end
      hpp_pkg::ST_HMUL: state_nxt = hpp_pkg::ST_HDIV;
      hpp_pkg::ST_HDIV: state_nxt = (m_r == 4'd1) ? hpp_pkg::ST_PMUL : hpp_pkg::ST_HMUL;
      hpp_pkg::ST_PMUL: state_nxt = hpp_pkg::ST_GROW;
      hpp_pkg::ST_GROW: state_nxt = hpp_pkg::ST_STEP;
      hpp_pkg::ST_STEP: begin
        state_nxt = (last_asset && last_step) ? hpp_pkg::ST_MDIV : hpp_pkg::ST_IDLE;
      end
      hpp_pkg::ST_MDIV: begin
        if (dcnt_r == 6'd0) begin
          state_nxt = hpp_pkg::ST_OPT;
        end
      end
      hpp_pkg::ST_OPT: state_nxt = hpp_pkg::ST_EMIT;
      hpp_pkg::ST_EMIT: begin
        if (can_emit) begin
          state_nxt = hpp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hpp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpp_pkg::ST_IDLE;
      strike_r    <= 32'd0;
      disc_r      <= 17'd65536;
      assets_r    <= 4'd1;
      steps_r     <= 16'd1;
      asset_pos_r <= '0;
      step_pos_r  <= 16'd0;
      mask_r      <= '1;
      fresh_r     <= '1;
      best_r      <= 32'd0;
      best_slot_r <= '0;
      sum_r       <= 40'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (hpp_pkg::cfg_reg_t'(cfg_index))
          hpp_pkg::REG_STRIKE:   strike_r <= cfg_data;
          hpp_pkg::REG_DISCOUNT: disc_r   <= cfg_data[16:0];
          hpp_pkg::REG_ASSETS:   assets_r <= cfg_data[3:0];
          hpp_pkg::REG_STEPS:    steps_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if ((state_r == hpp_pkg::ST_EMIT) && can_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == hpp_pkg::ST_LOAD) begin
        fresh_r[slot_r] <= 1'b0;
      end
      if (state_r == hpp_pkg::ST_GROW) begin
        fresh_r[asset_pos_r] <= 1'b0;
        if (grow_val >= best_r) begin
          best_r      <= grow_val;
          best_slot_r <= asset_pos_r;
        end
      end
      if (state_r == hpp_pkg::ST_STEP) begin
        if (!last_asset) begin
          asset_pos_r <= asset_pos_r + AW'(1);
        end else begin
          asset_pos_r <= '0;
          best_r      <= 32'd0;
          best_slot_r <= '0;
          if (!last_step) begin
            step_pos_r <= step_pos_r + 16'd1;
            if (do_remove) begin
              mask_r[best_slot_r] <= 1'b0;
              sum_r               <= sum_add;
            end
          end else begin
            step_pos_r <= 16'd0;
            mask_r     <= '1;
            sum_r      <= 40'd0;
            fresh_r    <= '1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      hpp_pkg::ST_IDLE: begin
        sample_r <= in_sample_value;
        slot_r   <= slot_addr;
        u_r      <= u_init[32:0];
        kq_r     <= 5'd0;
        jcnt_r   <= 3'd4;
        m_r      <= hpp_pkg::EXP_TERMS;
        e_r      <= hpp_pkg::ONE_Q28;
      end
      hpp_pkg::ST_RED: begin
        if (red_ge) begin
          u_r <= u_r - red_sub;
        end
        kq_r   <= {kq_r[3:0], red_ge};
        jcnt_r <= jcnt_r - 3'd1;
      end
      hpp_pkg::ST_HMUL: begin
        p_r <= {28'd0, e_r} * {30'd0, u_r[27:0]};
      end
      hpp_pkg::ST_HDIV: begin
        e_r <= e_next;
        m_r <= m_r - 4'd1;
      end
      hpp_pkg::ST_PMUL: begin
        prod_r <= {30'd0, price_cur} * {32'd0, e_r};
      end
      hpp_pkg::ST_STEP: begin
        dq_r   <= do_remove ? sum_add : sum_r;
        rem_r  <= '0;
        d_r    <= div_sel;
        dcnt_r <= 6'd39;
      end
      hpp_pkg::ST_MDIV: begin
        dq_r   <= {dq_r[38:0], div_ge};
        rem_r  <= rem_new[NW-1:0];
        dcnt_r <= dcnt_r - 6'd1;
      end
      hpp_pkg::ST_OPT: begin
        if (mean_sat > strike_r) begin
          opt_prod_r <= {17'd0, mean_sat - strike_r} * {32'd0, disc_r};
        end else begin
          opt_prod_r <= 49'd0;
        end
      end
      hpp_pkg::ST_EMIT: begin
        if (can_emit) begin
          out_opt_r  <= opt_val;
          out_mean_r <= mean_sat;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_option_value = out_opt_r;
  assign out_mean_of_best = out_mean_r;

  a_red_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hpp_pkg::ST_HMUL) |-> (u_r < hpp_pkg::LN2_Q28))
    else $error("range reduction left a remainder of ln 2 or more");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hpp_pkg::ST_MDIV) |-> (d_r != '0))
    else $error("mean divider started with a zero divisor");

  a_fresh_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hpp_pkg::ST_GROW) |=> !fresh_r[$past(asset_pos_r)]
      || ($past(last_asset) && $past(last_step)))
    else $error("working price written but still marked as the spot copy");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hpp_pkg::ST_EMIT) && !can_emit |=> (state_r == hpp_pkg::ST_EMIT) && out_valid_r)
    else $error("result left pending while the output was still held");

endmodule

`default_nettype wire
